FILE: hdl/dpnt_pkg.sv
// Shared types, constants and register codes for the drum pad note trigger.
`default_nettype none

package dpnt_pkg;

   localparam int DPNT_CHANNELS    = 8;
   localparam int DPNT_SAMPLE_BITS = 12;

   localparam int MAP_PADS     = 8;
   localparam int PAD_W        = 3;
   localparam int NOTE_W       = 7;
   localparam int GAIN_W       = 8;
   localparam int THRESHOLD_W  = 20;
   localparam int VEL_SCALE_W  = 16;
   localparam int HOLD_W       = 16;
   localparam int TIME_W       = 32;
   localparam int NOTE_MAP_W   = NOTE_W * MAP_PADS;
   localparam int CSR_INDEX_W  = 3;

   localparam logic [GAIN_W-1:0]      GAIN_RESET      = 8'd1;
   localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 20'd100;
   localparam logic                   VEL_EN_RESET    = 1'b1;
   localparam logic [VEL_SCALE_W-1:0] VEL_SCALE_RESET = 16'd256;
   localparam logic [NOTE_W-1:0]      MAX_VEL_RESET   = 7'd127;
   localparam logic [HOLD_W-1:0]      HOLD_RESET      = 16'd50;
   localparam logic [NOTE_MAP_W-1:0]  NOTE_MAP_RESET  = 56'd15535290419488818;

   localparam logic [NOTE_W-1:0]      NOTE_OFF_VEL_MAX = 7'd127;

   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_VEL_EN    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_VEL_SCALE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_VEL   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD      = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_NOTE_MAP  = 3'd6;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_LEVEL  = 4'b0010,
      ST_VEL    = 4'b0100,
      ST_DECIDE = 4'b1000
   } dpnt_state_type;

   typedef struct packed {
      logic load_in;
      logic calc_level;
      logic calc_vel;
      logic commit;
   } dpnt_cmd_type;

   typedef struct packed {
      logic has_event;
      logic out_blocked;
   } dpnt_status_type;

endpackage

`default_nettype wire

FILE: hdl/drum_pad_note_trigger.sv
// Top level of the drum pad note trigger: controller, datapath and ports.
`default_nettype none

// Each accepted sample transaction passes through the accept state, the gain
// multiply state, the velocity-scale multiply state and the decide state, which
// compares, updates the pad state and loads the result register. The block holds
// one sample at a time; a new sample is taken while a finished result still
// waits in the output register, and the decide state waits only when a new
// result is due while that register is still stalled. The configuration port
// is always ready and must be written only while no transaction is in flight.
module drum_pad_note_trigger
   import dpnt_pkg::*;
#(
   parameter int CHANNELS    = DPNT_CHANNELS,
   parameter int SAMPLE_BITS = DPNT_SAMPLE_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [NOTE_MAP_W-1:0]  csr_data,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [PAD_W-1:0]       req_pad_channel,
   input  wire logic [SAMPLE_BITS-1:0] req_sample,
   input  wire logic [TIME_W-1:0]      req_now_ms,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_is_note_off,
   output logic [NOTE_W-1:0]           rsp_note_number,
   output logic [NOTE_W-1:0]           rsp_note_velocity
);

   dpnt_cmd_type    cmd;
   dpnt_status_type status;

   assign csr_ready = 1'b1;

   dpnt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   dpnt_dp #(
      .CHANNELS    (CHANNELS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_pad_channel   (req_pad_channel),
      .req_sample        (req_sample),
      .req_now_ms        (req_now_ms),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_is_note_off   (rsp_is_note_off),
      .rsp_note_number   (rsp_note_number),
      .rsp_note_velocity (rsp_note_velocity),
      .cmd               (cmd),
      .status            (status)
   );

endmodule

`default_nettype wire

FILE: hdl/dpnt_ctrl.sv
// Controller state machine that sequences one pad sample through the datapath.
`default_nettype none

module dpnt_ctrl
   import dpnt_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire dpnt_status_type status,
   output dpnt_cmd_type         cmd
);

   dpnt_state_type state_ff;
   dpnt_state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_LEVEL;
            end
         end
         ST_LEVEL: begin
            cmd.calc_level = 1'b1;
            state_in       = ST_VEL;
         end
         ST_VEL: begin
            cmd.calc_vel = 1'b1;
            state_in     = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!(status.has_event && status.out_blocked)) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_in, cmd.calc_level, cmd.calc_vel, cmd.commit}))
      else $error("More than one datapath command in a cycle.");

   assert property (@(posedge clock) disable iff (reset)
      cmd.load_in |=> cmd.calc_level ##1 cmd.calc_vel)
      else $error("Accepted transaction was not sequenced through both multiplies.");

   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> !req_stall)
      else $error("Controller did not return to idle after commit.");
`endif

endmodule

`default_nettype wire

FILE: hdl/dpnt_dp.sv
// Datapath with configuration registers, pad state, multipliers and result register.
`default_nettype none

module dpnt_dp
   import dpnt_pkg::*;
#(
   parameter int CHANNELS    = DPNT_CHANNELS,
   parameter int SAMPLE_BITS = DPNT_SAMPLE_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [NOTE_MAP_W-1:0]  csr_data,
   input  wire logic [PAD_W-1:0]       req_pad_channel,
   input  wire logic [SAMPLE_BITS-1:0] req_sample,
   input  wire logic [TIME_W-1:0]      req_now_ms,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_is_note_off,
   output logic [NOTE_W-1:0]           rsp_note_number,
   output logic [NOTE_W-1:0]           rsp_note_velocity,
   input  wire dpnt_cmd_type           cmd,
   output dpnt_status_type             status
);

   localparam int NUM_PADS = (CHANNELS < MAP_PADS) ? CHANNELS : MAP_PADS;
   localparam int IDX_W    = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;
   localparam int LEVEL_W  = SAMPLE_BITS + GAIN_W;
   localparam int PROD_W   = LEVEL_W + VEL_SCALE_W;
   localparam int SHIFT_W  = PROD_W - 8;
   localparam int CMP_W    = (LEVEL_W > THRESHOLD_W) ? LEVEL_W : THRESHOLD_W;

   logic [GAIN_W-1:0]      gain_ff;
   logic [THRESHOLD_W-1:0] threshold_ff;
   logic                   vel_en_ff;
   logic [VEL_SCALE_W-1:0] vel_scale_ff;
   logic [NOTE_W-1:0]      max_vel_ff;
   logic [HOLD_W-1:0]      hold_ff;
   logic [NOTE_MAP_W-1:0]  note_map_ff;

   logic [PAD_W-1:0]       pad_ff;
   logic [SAMPLE_BITS-1:0] sample_ff;
   logic [TIME_W-1:0]      now_ff;
   logic [LEVEL_W-1:0]     level_ff;
   logic [PROD_W-1:0]      prod_ff;

   logic                   active_ff [NUM_PADS];
   logic [TIME_W-1:0]      start_ff  [NUM_PADS];

   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   rsp_off_ff;
   logic [NOTE_W-1:0]      rsp_note_ff;
   logic [NOTE_W-1:0]      rsp_vel_ff;

   logic [NOTE_W-1:0]      notes [MAP_PADS];
   logic [IDX_W-1:0]       idx;
   logic                   pad_ok;
   logic                   above;
   logic [TIME_W-1:0]      elapsed;
   logic                   on_evt;
   logic                   off_evt;
   logic [SHIFT_W-1:0]     scaled;
   logic [NOTE_W-1:0]      on_vel;
   logic [NOTE_W-1:0]      off_vel;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= GAIN_RESET;
         threshold_ff <= THRESHOLD_RESET;
         vel_en_ff    <= VEL_EN_RESET;
         vel_scale_ff <= VEL_SCALE_RESET;
         max_vel_ff   <= MAX_VEL_RESET;
         hold_ff      <= HOLD_RESET;
         note_map_ff  <= NOTE_MAP_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_GAIN:      gain_ff      <= csr_data[GAIN_W-1:0];
            CSR_THRESHOLD: threshold_ff <= csr_data[THRESHOLD_W-1:0];
            CSR_VEL_EN:    vel_en_ff    <= csr_data[0];
            CSR_VEL_SCALE: vel_scale_ff <= csr_data[VEL_SCALE_W-1:0];
            CSR_MAX_VEL:   max_vel_ff   <= csr_data[NOTE_W-1:0];
            CSR_HOLD:      hold_ff      <= csr_data[HOLD_W-1:0];
            CSR_NOTE_MAP:  note_map_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         pad_ff    <= req_pad_channel;
         sample_ff <= req_sample;
         now_ff    <= req_now_ms;
      end
      if (cmd.calc_level) begin
         level_ff <= LEVEL_W'(sample_ff) * LEVEL_W'(gain_ff);
      end
      if (cmd.calc_vel) begin
         prod_ff <= PROD_W'(level_ff) * PROD_W'(vel_scale_ff);
      end
   end

   always_comb begin
      for (int i = 0; i < MAP_PADS; i++) begin
         notes[i] = note_map_ff[i*NOTE_W +: NOTE_W];
      end
   end

   assign idx     = IDX_W'(pad_ff);
   assign pad_ok  = ({1'b0, pad_ff} < (PAD_W + 1)'(NUM_PADS));
   assign above   = (CMP_W'(level_ff) > CMP_W'(threshold_ff));
   assign elapsed = now_ff - start_ff[idx];
   assign on_evt  = pad_ok && above && !active_ff[idx];
   assign off_evt = pad_ok && !above && active_ff[idx] && (elapsed > TIME_W'(hold_ff));

   assign scaled  = prod_ff[PROD_W-1:8];
   assign on_vel  = !vel_en_ff ? max_vel_ff :
                    (scaled > SHIFT_W'(max_vel_ff)) ? max_vel_ff : scaled[NOTE_W-1:0];
   assign off_vel = (level_ff > LEVEL_W'(NOTE_OFF_VEL_MAX)) ? NOTE_OFF_VEL_MAX
                                                            : level_ff[NOTE_W-1:0];

   assign status.has_event   = on_evt || off_evt;
   assign status.out_blocked = rsp_valid_ff && rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PADS; i++) begin
            active_ff[i] <= 1'b0;
         end
      end else if (cmd.commit && (on_evt || off_evt)) begin
         active_ff[idx] <= on_evt;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && (on_evt || off_evt)) begin
         start_ff[idx] <= now_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.commit && (on_evt || off_evt)) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && (on_evt || off_evt)) begin
         rsp_off_ff  <= off_evt;
         rsp_note_ff <= notes[pad_ff];
         rsp_vel_ff  <= on_evt ? on_vel : off_vel;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_is_note_off   = rsp_off_ff;
   assign rsp_note_number   = rsp_note_ff;
   assign rsp_note_velocity = rsp_vel_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && status.has_event) |-> !(rsp_valid_ff && rsp_stall))
      else $error("Result register overwritten while a transaction was pending.");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.commit))
      else $error("Result became valid without a commit.");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && on_evt) |=> active_ff[idx])
      else $error("Note-on did not mark the pad active.");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && off_evt) |=> !active_ff[idx])
      else $error("Note-off did not clear the pad.");
`endif

endmodule

`default_nettype wire

FILE: verif/drum_pad_note_trigger_tb.sv
// Self-checking testbench for the drum pad note trigger with a note event scoreboard.
`timescale 1ns / 1ps

module drum_pad_note_trigger_tb;
   import dpnt_pkg::*;

   localparam int LEVEL_W       = DPNT_SAMPLE_BITS + GAIN_W;
   localparam int SAMPLE_MAX    = (1 << DPNT_SAMPLE_BITS) - 1;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD     = 400;
   localparam int IDLE_LIMIT    = 3000;
   localparam int REPORT_LINES  = 100;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;

   typedef struct packed {
      logic              note_off;
      logic [NOTE_W-1:0] note;
      logic [NOTE_W-1:0] velocity;
   } note_event_type;

   class note_event_board;
      logic [GAIN_W-1:0]      gain;
      logic [THRESHOLD_W-1:0] threshold;
      logic                   vel_en;
      logic [VEL_SCALE_W-1:0] vel_scale;
      logic [NOTE_W-1:0]      max_vel;
      logic [HOLD_W-1:0]      hold_ms;
      logic [NOTE_MAP_W-1:0]  note_map;
      logic                   sounding [DPNT_CHANNELS];
      logic [TIME_W-1:0]      started_at [DPNT_CHANNELS];
      note_event_type         due_events [$];
      int                     mismatches;

      function new();
         gain      = GAIN_RESET;
         threshold = THRESHOLD_RESET;
         vel_en    = VEL_EN_RESET;
         vel_scale = VEL_SCALE_RESET;
         max_vel   = MAX_VEL_RESET;
         hold_ms   = HOLD_RESET;
         note_map  = NOTE_MAP_RESET;
         for (int i = 0; i < DPNT_CHANNELS; i++) begin
            sounding[i]   = 1'b0;
            started_at[i] = '0;
         end
         mismatches = 0;
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] index, logic [NOTE_MAP_W-1:0] data);
         case (index)
            CSR_GAIN:      gain      = data[GAIN_W-1:0];
            CSR_THRESHOLD: threshold = data[THRESHOLD_W-1:0];
            CSR_VEL_EN:    vel_en    = data[0];
            CSR_VEL_SCALE: vel_scale = data[VEL_SCALE_W-1:0];
            CSR_MAX_VEL:   max_vel   = data[NOTE_W-1:0];
            CSR_HOLD:      hold_ms   = data[HOLD_W-1:0];
            CSR_NOTE_MAP:  note_map  = data;
            default: ;
         endcase
      endfunction

      function void take_sample(logic [PAD_W-1:0] pad, logic [DPNT_SAMPLE_BITS-1:0] sample,
                                logic [TIME_W-1:0] now);
         logic [LEVEL_W-1:0]             level;
         logic [LEVEL_W+VEL_SCALE_W-1:0] scaled;
         logic [TIME_W-1:0]              elapsed;
         note_event_type                 ev;
         level   = sample * gain;
         ev.note = note_map[pad * NOTE_W +: NOTE_W];
         if (level > threshold) begin
            if (sounding[pad]) return;
            scaled = level * vel_scale;
            if (!vel_en || (scaled >> 8) > max_vel) ev.velocity = max_vel;
            else ev.velocity = scaled[NOTE_W+7:8];
            ev.note_off   = 1'b0;
            sounding[pad] = 1'b1;
         end else begin
            elapsed = now - started_at[pad];
            if (!sounding[pad] || elapsed <= hold_ms) return;
            ev.note_off   = 1'b1;
            ev.velocity   = (level > NOTE_OFF_VEL_MAX) ? NOTE_OFF_VEL_MAX : level[NOTE_W-1:0];
            sounding[pad] = 1'b0;
         end
         started_at[pad] = now;
         due_events.push_back(ev);
      endfunction

      task report(string msg);
         if (mismatches < REPORT_LINES) $display("mismatch at %0t: %s", $time, msg);
         mismatches++;
      endtask

      task check_event(logic note_off, logic [NOTE_W-1:0] note, logic [NOTE_W-1:0] velocity);
         note_event_type ev;
         if (due_events.size() == 0) begin
            report($sformatf("unexpected event off=%0b note=%0d velocity=%0d",
                             note_off, note, velocity));
            return;
         end
         ev = due_events.pop_front();
         if (note_off !== ev.note_off)
            report($sformatf("is_note_off %0b, expected %0b", note_off, ev.note_off));
         if (note !== ev.note)
            report($sformatf("note_number %0d, expected %0d", note, ev.note));
         if (velocity !== ev.velocity)
            report($sformatf("note_velocity %0d, expected %0d", velocity, ev.velocity));
      endtask
   endclass

   logic                        clock;
   logic                        reset;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [CSR_INDEX_W-1:0]      csr_index;
   logic [NOTE_MAP_W-1:0]       csr_data;
   logic                        req_valid;
   logic                        req_stall;
   logic [PAD_W-1:0]            req_pad_channel;
   logic [DPNT_SAMPLE_BITS-1:0] req_sample;
   logic [TIME_W-1:0]           req_now_ms;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic                        rsp_is_note_off;
   logic [NOTE_W-1:0]           rsp_note_number;
   logic [NOTE_W-1:0]           rsp_note_velocity;

   note_event_board board = new();

   bit               pressure_go;
   bit               pressure_done;
   int               idle_cycles;
   logic [TIME_W-1:0] ms_base;
   logic [PAD_W-1:0]  last_pad;

   drum_pad_note_trigger dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pad_channel   (req_pad_channel),
      .req_sample        (req_sample),
      .req_now_ms        (req_now_ms),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_is_note_off   (rsp_is_note_off),
      .rsp_note_number   (rsp_note_number),
      .rsp_note_velocity (rsp_note_velocity)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   always @(posedge clock) begin : monitor
      bit progress;
      progress = 1'b0;
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            board.check_event(rsp_is_note_off, rsp_note_number, rsp_note_velocity);
            progress = 1'b1;
         end
         if (req_valid && !req_stall) begin
            board.take_sample(req_pad_channel, req_sample, req_now_ms);
            progress = 1'b1;
         end
         if (csr_valid && csr_ready) begin
            board.set_register(csr_index, csr_data);
            progress = 1'b1;
         end
         idle_cycles = progress ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // The receiver switches between stall patterns and holds off once for a long stretch.
   initial begin : receiver
      int seg_left;
      int mode;
      int hold_left;
      seg_left      = 0;
      mode          = 0;
      hold_left     = 0;
      pressure_done = 1'b0;
      rsp_stall     = 1'b0;
      forever begin
         @(posedge clock);
         if (pressure_go && !pressure_done) begin
            hold_left     = LONG_HOLD;
            pressure_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (seg_left == 0) begin
               mode     = $urandom_range(0, 3);
               seg_left = $urandom_range(10, 150);
            end
            seg_left--;
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   task automatic offer_sample(input logic [PAD_W-1:0] pad,
                               input logic [DPNT_SAMPLE_BITS-1:0] sample,
                               input logic [TIME_W-1:0] now);
      req_valid       <= 1'b1;
      req_pad_channel <= pad;
      req_sample      <= sample;
      req_now_ms      <= now;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [NOTE_MAP_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic settle();
      do @(posedge clock); while (board.due_events.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(input int phase);
      logic [GAIN_W-1:0]      g;
      logic [THRESHOLD_W-1:0] thr;
      logic                   en;
      logic [VEL_SCALE_W-1:0] scale;
      logic [NOTE_W-1:0]      max_vel;
      logic [HOLD_W-1:0]      hold;
      logic [63:0]            map;
      g       = GAIN_W'($urandom_range(1, 255));
      thr     = THRESHOLD_W'($urandom_range(0, SAMPLE_MAX * g));
      en      = 1'($urandom_range(0, 1));
      scale   = VEL_SCALE_W'($urandom_range(0, 1) ? $urandom_range(0, 64)
                                                   : $urandom_range(0, 65535));
      max_vel = NOTE_W'($urandom_range(0, 127));
      hold    = HOLD_W'($urandom_range(0, 200));
      map     = {$urandom, $urandom};
      case (phase)
         1: begin
            g       = 8'd255;
            thr     = '0;
            en      = 1'b1;
            scale   = '1;
            max_vel = 7'd127;
            hold    = '0;
            map     = '1;
         end
         2: begin
            g   = 8'd1;
            thr = '1;
         end
         3: begin
            en      = 1'b0;
            scale   = '0;
            max_vel = '0;
            hold    = '1;
            map     = '0;
         end
         default: ;
      endcase
      write_register(CSR_UNUSED, map[NOTE_MAP_W-1:0]);
      write_register(CSR_GAIN, NOTE_MAP_W'(g));
      write_register(CSR_THRESHOLD, NOTE_MAP_W'(thr));
      write_register(CSR_VEL_EN, NOTE_MAP_W'(en));
      write_register(CSR_VEL_SCALE, NOTE_MAP_W'(scale));
      write_register(CSR_MAX_VEL, NOTE_MAP_W'(max_vel));
      write_register(CSR_HOLD, NOTE_MAP_W'(hold));
      write_register(CSR_NOTE_MAP, map[NOTE_MAP_W-1:0]);
      csr_valid <= 1'b0;
   endtask

   // Strikes and decays on the same pad dominate, with samples on both sides of the
   // threshold, some right at it, and some timestamps at the end of the hold time.
   task automatic pick_sample(output logic [PAD_W-1:0] pad,
                              output logic [DPNT_SAMPLE_BITS-1:0] sample,
                              output logic [TIME_W-1:0] now);
      int unsigned cut;
      cut = board.threshold / board.gain;
      pad = $urandom_range(0, 1) ? last_pad : PAD_W'($urandom_range(0, DPNT_CHANNELS - 1));
      last_pad = pad;
      case ($urandom_range(0, 9))
         0: sample = DPNT_SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
         1: sample = (cut >= SAMPLE_MAX) ? DPNT_SAMPLE_BITS'(SAMPLE_MAX)
                                         : DPNT_SAMPLE_BITS'(cut + $urandom_range(0, 1));
         2, 3, 4, 5: begin
            if (cut >= SAMPLE_MAX) sample = DPNT_SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
            else sample = DPNT_SAMPLE_BITS'($urandom_range(cut + 1, SAMPLE_MAX));
         end
         default: sample = DPNT_SAMPLE_BITS'($urandom_range(0,
                                             (cut > SAMPLE_MAX) ? SAMPLE_MAX : cut));
      endcase
      case ($urandom_range(0, 7))
         0: now = board.started_at[pad] + board.hold_ms + $urandom_range(0, 1);
         1: now = $urandom;
         default: begin
            ms_base = ms_base + $urandom_range(0, board.hold_ms / 3 + 2);
            now     = ms_base;
         end
      endcase
   endtask

   initial begin : stimulus
      logic [PAD_W-1:0]            pad;
      logic [DPNT_SAMPLE_BITS-1:0] sample;
      logic [TIME_W-1:0]           now;
      int                          burst_left;
      int                          gap;
      int                          count;
      reset           = 1'b1;
      csr_valid       = 1'b0;
      csr_index       = '0;
      csr_data        = '0;
      req_valid       = 1'b0;
      req_pad_channel = '0;
      req_sample      = '0;
      req_now_ms      = '0;
      pressure_go     = 1'b0;
      burst_left      = 0;
      ms_base         = $urandom;
      last_pad        = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: threshold boundary, hold boundary and timestamp wrap.
      offer_sample(3'd0, 12'd0, 32'd0);
      offer_sample(3'd0, 12'd100, 32'd1);
      offer_sample(3'd0, 12'd101, 32'd2);
      offer_sample(3'd0, 12'd4095, 32'd3);
      offer_sample(3'd0, 12'd50, 32'd52);
      offer_sample(3'd0, 12'd50, 32'd53);
      offer_sample(3'd7, 12'd4095, 32'hFFFF_FFF0);
      offer_sample(3'd7, 12'd0, 32'h0000_0023);
      offer_sample(3'd3, 12'd200, 32'hFFFF_FFFF);
      req_valid <= 1'b0;
      settle();

      // Zero velocity note-on, zero hold time and a clamped note-off velocity.
      write_register(CSR_GAIN, NOTE_MAP_W'(8'd2));
      write_register(CSR_THRESHOLD, NOTE_MAP_W'(20'd1000));
      write_register(CSR_VEL_SCALE, NOTE_MAP_W'(16'd0));
      write_register(CSR_HOLD, NOTE_MAP_W'(16'd0));
      csr_valid <= 1'b0;
      offer_sample(3'd1, 12'd501, 32'd10);
      offer_sample(3'd1, 12'd500, 32'd10);
      offer_sample(3'd1, 12'd500, 32'd11);
      offer_sample(3'd2, 12'd4095, 32'd20);
      offer_sample(3'd2, 12'd30, 32'd21);
      offer_sample(3'd3, 12'd0, 32'd0);
      req_valid <= 1'b0;
      settle();

      for (int phase = 1; phase <= 8; phase++) begin
         apply_settings(phase);
         if (phase == 4) pressure_go = 1'b1;
         count = (phase == 2) ? 60 : 240;
         for (int n = 0; n < count; n++) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               if (gap > 0) begin
                  req_valid <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
            end
            burst_left--;
            pick_sample(pad, sample, now);
            offer_sample(pad, sample, now);
         end
         req_valid <= 1'b0;
         settle();
      end

      if (board.mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
